// File: rtl/sorted_deadline_timer_queue_defines.svh
// Assertion macros for the sorted deadline timer queue.
// Used by the top level only; assumes signals clk and rst_n are in scope.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define SDTQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdtq: same-cycle check failed");
`define SDTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdtq: next-cycle check failed");
`else
`define SDTQ_ASSERT_NOW(lbl, ante, cons)
`define SDTQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/sdtq_pkg.sv
// Package for the sorted deadline timer queue: field widths, codes and shared types.
// No dependencies; used by the interfaces, the cell and the top level.
package sdtq_pkg;

    localparam int CMD_W       = 2;
    localparam int JOB_IN_W    = 8;
    localparam int TIME_IN_W   = 32;
    localparam int STATUS_W    = 3;
    localparam int PENDING_W   = 5;

    localparam int CAPACITY_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int JOB_BITS_DEF  = 8;
    localparam int MAX_RESULTS   = 16;

    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    localparam logic [STATUS_W-1:0] STS_SCHEDULED = 3'd0;
    localparam logic [STATUS_W-1:0] STS_REJECTED  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_CANCELLED = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STS_EXPIRED   = 3'd4;
    localparam logic [STATUS_W-1:0] STS_NONE_DUE  = 3'd5;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SHIFT,
        CELL_MARK
    } cell_op_t;

    // Status one cell shows its neighbors.
    typedef struct packed {
        logic valid;
        logic keep;
        logic found;
        logic expired;
    } link_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_EMIT
    } fsm_state_t;

endpackage

// File: rtl/sdtq_if.sv
// Request and response channel interfaces of the sorted deadline timer queue.
// Depends on sdtq_pkg for the field widths.
interface sdtq_req_if;
    logic                               valid;
    logic                               ready;
    logic [sdtq_pkg::CMD_W-1:0]         cmd;
    logic [sdtq_pkg::JOB_IN_W-1:0]      job_id;
    logic [sdtq_pkg::TIME_IN_W-1:0]     delay;
    logic [sdtq_pkg::TIME_IN_W-1:0]     now;

    modport source (output valid, cmd, job_id, delay, now, input ready);
    modport sink (input valid, cmd, job_id, delay, now, output ready);
endinterface

interface sdtq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [sdtq_pkg::STATUS_W-1:0]      status;
    logic [sdtq_pkg::JOB_IN_W-1:0]      out_job;
    logic                               last;
    logic [sdtq_pkg::PENDING_W-1:0]     pending;

    modport source (output valid, status, out_job, last, pending, input ready);
    modport sink (input valid, status, out_job, last, pending, output ready);
endinterface

// File: rtl/sdtq_cell.sv
// One slot of the timer table: a deadline, a job id, a valid bit and an expiry mark.
// Depends on sdtq_pkg; instantiated in a row by the top level.
module sdtq_cell #(
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF,
    parameter int JOB_BITS  = sdtq_pkg::JOB_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdtq_pkg::cell_op_t   op,
    input  logic [TIME_BITS-1:0] key,
    input  logic [JOB_BITS-1:0]  new_job,
    input  logic                 exp_en,
    input  sdtq_pkg::link_t      prev_link,
    input  logic [TIME_BITS-1:0] prev_deadline,
    input  logic [JOB_BITS-1:0]  prev_job,
    input  sdtq_pkg::link_t      next_link,
    input  logic [TIME_BITS-1:0] next_deadline,
    input  logic [JOB_BITS-1:0]  next_job,
    output sdtq_pkg::link_t      link,
    output logic [TIME_BITS-1:0] deadline,
    output logic [JOB_BITS-1:0]  job
);

    logic                 valid_reg, valid_next;
    logic                 exp_reg, exp_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;
    logic [JOB_BITS-1:0]  job_reg, job_next;
    logic                 keep;
    logic                 found;

    // An entry stays put on insert when its deadline is not later than the new one.
    assign keep  = valid_reg && !(key < dl_reg);
    assign found = prev_link.found || (valid_reg && (job_reg == new_job));

    assign link     = '{valid: valid_reg, keep: keep, found: found, expired: exp_reg};
    assign deadline = dl_reg;
    assign job      = job_reg;

    always_comb
    begin
        valid_next = valid_reg;
        exp_next   = exp_reg;
        dl_next    = dl_reg;
        job_next   = job_reg;
        case (op)
            sdtq_pkg::CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_link.keep)
                    begin
                        valid_next = 1'b1;
                        dl_next    = key;
                        job_next   = new_job;
                    end
                    else
                    begin
                        valid_next = prev_link.valid;
                        dl_next    = prev_deadline;
                        job_next   = prev_job;
                    end
                end
            end
            sdtq_pkg::CELL_REMOVE:
            begin
                if (found)
                begin
                    valid_next = next_link.valid;
                    dl_next    = next_deadline;
                    job_next   = next_job;
                end
            end
            sdtq_pkg::CELL_SHIFT:
            begin
                valid_next = next_link.valid;
                exp_next   = next_link.expired;
                dl_next    = next_deadline;
                job_next   = next_job;
            end
            sdtq_pkg::CELL_MARK:
            begin
                exp_next = exp_en && valid_reg && (dl_reg < key);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            exp_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            exp_reg   <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg  <= dl_next;
        job_reg <= job_next;
    end

endmodule

// File: rtl/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue: control sequencer and the row of cells.
// Depends on sdtq_pkg, sdtq_if.sv, sdtq_cell and sorted_deadline_timer_queue_defines.svh.
//
// Usage: items arrive on req (cmd, job_id, delay, now) under valid/ready and results
// leave on rsp (status, out_job, last, pending) from an output register.
// The table is a row of cells kept in ascending deadline order; every cell
// compares its deadline against a broadcast key and takes its own value or
// that of a neighbor in the same cycle.
// Schedule and cancel: the item is taken in IDLE and applied to the row in EXEC,
// which loads its single result into the output register; a new item is taken
// only once the block is back in IDLE.
// Tick: the item is taken in IDLE, EXEC marks the due cells, then EMIT gives one
// result per cycle while rsp does not stall, as the row shifts the earliest entry
// out; at most 16 expiries per tick. A tick with nothing due gives a single result.
// The block works on one item at a time; req.ready is high only while it is free.
// Reset empties the table at once. When rsp stalls, the finished result waits in
// the output register and the row holds until it has been taken.
`include "sorted_deadline_timer_queue_defines.svh"

module sorted_deadline_timer_queue #(
    parameter int CAPACITY  = sdtq_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF,
    parameter int JOB_BITS  = sdtq_pkg::JOB_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    sdtq_req_if.sink   req,
    sdtq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    sdtq_pkg::fsm_state_t state_reg, state_next;

    logic [sdtq_pkg::CMD_W-1:0] cmd_reg;
    logic [JOB_BITS-1:0]        job_reg;
    logic [TIME_BITS-1:0]       key_reg;
    logic [CNT_W-1:0]           count_reg, count_next;

    logic                             out_valid_reg;
    logic [sdtq_pkg::STATUS_W-1:0]    out_status_reg;
    logic [sdtq_pkg::JOB_IN_W-1:0]    out_job_reg;
    logic                             out_last_reg;
    logic [sdtq_pkg::PENDING_W-1:0]   out_pending_reg;

    logic                   accept;
    logic                   out_free;
    logic [TIME_BITS-1:0]   now_val;
    logic [TIME_BITS:0]     due_sum;
    logic [TIME_BITS-1:0]   due_val;

    sdtq_pkg::cell_op_t            cell_op;
    logic                          load_out;
    logic [sdtq_pkg::STATUS_W-1:0] res_status;
    logic [JOB_BITS-1:0]           res_job;
    logic                          res_last;
    logic [CNT_W-1:0]              res_pending;

    sdtq_pkg::link_t      cell_link [CAPACITY];
    logic [TIME_BITS-1:0] cell_dl   [CAPACITY];
    logic [JOB_BITS-1:0]  cell_job  [CAPACITY];
    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY:0]    exp_ext;
    logic [CNT_W-1:0]     due_cnt;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == sdtq_pkg::FSM_IDLE);

    // Deadline = now + delay, saturating at the all-ones time.
    assign now_val = TIME_BITS'(req.now);
    assign due_sum = {1'b0, now_val} + {1'b0, TIME_BITS'(req.delay)};
    assign due_val = due_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : due_sum[TIME_BITS-1:0];

    // Row of cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sdtq_pkg::link_t      p_link;
        logic [TIME_BITS-1:0] p_dl;
        logic [JOB_BITS-1:0]  p_job;
        sdtq_pkg::link_t      n_link;
        logic [TIME_BITS-1:0] n_dl;
        logic [JOB_BITS-1:0]  n_job;

        if (i == 0)
        begin : g_head
            assign p_link = '{valid: 1'b1, keep: 1'b1, found: 1'b0, expired: 1'b0};
            assign p_dl   = '0;
            assign p_job  = '0;
        end
        else
        begin : g_body
            assign p_link = cell_link[i-1];
            assign p_dl   = cell_dl[i-1];
            assign p_job  = cell_job[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign n_link = '{valid: 1'b0, keep: 1'b0, found: 1'b0, expired: 1'b0};
            assign n_dl   = '0;
            assign n_job  = '0;
        end
        else
        begin : g_mid
            assign n_link = cell_link[i+1];
            assign n_dl   = cell_dl[i+1];
            assign n_job  = cell_job[i+1];
        end

        sdtq_cell #(
            .TIME_BITS (TIME_BITS),
            .JOB_BITS  (JOB_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .op            (cell_op),
            .key           (key_reg),
            .new_job       (job_reg),
            .exp_en        (i < sdtq_pkg::MAX_RESULTS),
            .prev_link     (p_link),
            .prev_deadline (p_dl),
            .prev_job      (p_job),
            .next_link     (n_link),
            .next_deadline (n_dl),
            .next_job      (n_job),
            .link          (cell_link[i]),
            .deadline      (cell_dl[i]),
            .job           (cell_job[i])
        );

        assign valid_vec[i] = cell_link[i].valid;
        assign exp_ext[i]   = cell_link[i].expired;
    end

    assign exp_ext[CAPACITY] = 1'b0;

    // The expiry marks form a run from cell 0; its length is the number still due.
    always_comb
    begin
        due_cnt = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (exp_ext[i] && !exp_ext[i+1])
                due_cnt = due_cnt | CNT_W'(i + 1);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdtq_pkg::FSM_IDLE:
            begin
                if (accept)
                    state_next = sdtq_pkg::FSM_EXEC;
            end
            sdtq_pkg::FSM_EXEC:
            begin
                if (cmd_reg == sdtq_pkg::CMD_TICK)
                    state_next = sdtq_pkg::FSM_EMIT;
                else if (cmd_reg != sdtq_pkg::CMD_SCHEDULE && cmd_reg != sdtq_pkg::CMD_CANCEL)
                    state_next = sdtq_pkg::FSM_IDLE;
                else if (out_free)
                    state_next = sdtq_pkg::FSM_IDLE;
            end
            sdtq_pkg::FSM_EMIT:
            begin
                if (out_free && due_cnt <= CNT_W'(1))
                    state_next = sdtq_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = sdtq_pkg::FSM_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: row operation, result and count update.
    always_comb
    begin
        cell_op     = sdtq_pkg::CELL_HOLD;
        load_out    = 1'b0;
        res_status  = sdtq_pkg::STS_NONE_DUE;
        res_job     = job_reg;
        res_last    = 1'b1;
        res_pending = count_reg;
        count_next  = count_reg;
        unique case (state_reg)
            sdtq_pkg::FSM_IDLE:
            begin
            end
            sdtq_pkg::FSM_EXEC:
            begin
                case (cmd_reg)
                    sdtq_pkg::CMD_SCHEDULE:
                    begin
                        if (out_free)
                        begin
                            load_out = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY))
                                res_status = sdtq_pkg::STS_REJECTED;
                            else
                            begin
                                cell_op     = sdtq_pkg::CELL_INSERT;
                                res_status  = sdtq_pkg::STS_SCHEDULED;
                                count_next  = count_reg + CNT_W'(1);
                                res_pending = count_next;
                            end
                        end
                    end
                    sdtq_pkg::CMD_CANCEL:
                    begin
                        if (out_free)
                        begin
                            load_out = 1'b1;
                            if (cell_link[CAPACITY-1].found)
                            begin
                                cell_op     = sdtq_pkg::CELL_REMOVE;
                                res_status  = sdtq_pkg::STS_CANCELLED;
                                count_next  = count_reg - CNT_W'(1);
                                res_pending = count_next;
                            end
                            else
                                res_status = sdtq_pkg::STS_NOT_FOUND;
                        end
                    end
                    sdtq_pkg::CMD_TICK:
                    begin
                        cell_op = sdtq_pkg::CELL_MARK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sdtq_pkg::FSM_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (due_cnt == '0)
                    begin
                        res_status = sdtq_pkg::STS_NONE_DUE;
                        res_job    = '0;
                    end
                    else
                    begin
                        // Every expiry of one tick reports the count left after the tick.
                        cell_op     = sdtq_pkg::CELL_SHIFT;
                        res_status  = sdtq_pkg::STS_EXPIRED;
                        res_job     = cell_job[0];
                        res_last    = (due_cnt == CNT_W'(1));
                        res_pending = count_reg - due_cnt;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdtq_pkg::FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            job_reg <= JOB_BITS'(req.job_id);
            key_reg <= (req.cmd == sdtq_pkg::CMD_TICK) ? now_val : due_val;
        end
        if (load_out)
        begin
            out_status_reg  <= res_status;
            out_job_reg     <= sdtq_pkg::JOB_IN_W'(res_job);
            out_last_reg    <= res_last;
            out_pending_reg <= sdtq_pkg::PENDING_W'(res_pending);
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.out_job = out_job_reg;
    assign rsp.last    = out_last_reg;
    assign rsp.pending = out_pending_reg;

    `SDTQ_ASSERT_NOW(a_count_matches_row, 1'b1, $countones(valid_vec) == count_reg)
    `SDTQ_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SDTQ_ASSERT_NOW(a_emit_head_valid, state_reg == sdtq_pkg::FSM_EMIT && due_cnt != '0, valid_vec[0] && exp_ext[0])
    `SDTQ_ASSERT_NEXT(a_mark_then_emit, state_reg == sdtq_pkg::FSM_EXEC && cmd_reg == sdtq_pkg::CMD_TICK, state_reg == sdtq_pkg::FSM_EMIT)

endmodule

// File: dv/timer_queue_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sorted deadline timer queue: watches both channels, keeps its own
// deadline-ordered table and checks every result field by field against it.
// Depends on sdtq_pkg and the request and response interfaces in sdtq_if.sv.
module timer_queue_checker (
    input  logic clk,
    input  logic rst_n,
    sdtq_req_if  req,
    sdtq_rsp_if  rsp,
    output int   fail_count,
    output int   owed
);

    localparam int DEPTH = sdtq_pkg::CAPACITY_DEF;

    typedef struct packed {
        logic [sdtq_pkg::STATUS_W-1:0]  status;
        logic [sdtq_pkg::JOB_IN_W-1:0]  job;
        logic                           last;
        logic [sdtq_pkg::PENDING_W-1:0] pending;
    } timer_result_t;

    logic [sdtq_pkg::TIME_IN_W-1:0] deadline_row [DEPTH];
    logic [sdtq_pkg::JOB_IN_W-1:0]  job_row [DEPTH];
    int                             entries;
    timer_result_t                  answers_owed [$];

    task automatic owe(input logic [sdtq_pkg::STATUS_W-1:0] status,
                       input logic [sdtq_pkg::JOB_IN_W-1:0] job,
                       input logic last);
        timer_result_t r;
        r.status  = status;
        r.job     = job;
        r.last    = last;
        r.pending = entries[sdtq_pkg::PENDING_W-1:0];
        answers_owed.push_back(r);
    endtask

    // Applies one accepted command to the table and queues the results it must cause.
    task automatic predict_command(input logic [sdtq_pkg::CMD_W-1:0] cmd,
                                   input logic [sdtq_pkg::JOB_IN_W-1:0] job,
                                   input logic [sdtq_pkg::TIME_IN_W-1:0] dly,
                                   input logic [sdtq_pkg::TIME_IN_W-1:0] tnow);
        logic [sdtq_pkg::TIME_IN_W:0]   sum;
        logic [sdtq_pkg::TIME_IN_W-1:0] due;
        logic [sdtq_pkg::JOB_IN_W-1:0]  gone [sdtq_pkg::MAX_RESULTS];
        int                             pos;
        int                             n;
        int                             i;
        case (cmd)
            sdtq_pkg::CMD_SCHEDULE:
            begin
                if (entries >= DEPTH)
                begin
                    owe(sdtq_pkg::STS_REJECTED, job, 1'b1);
                end
                else
                begin
                    sum = {1'b0, tnow} + {1'b0, dly};
                    due = sum[sdtq_pkg::TIME_IN_W] ? '1 : sum[sdtq_pkg::TIME_IN_W-1:0];
                    // Equal deadlines keep arrival order, so insert after them.
                    pos = 0;
                    while (pos < entries && !(due < deadline_row[pos]))
                        pos++;
                    for (i = entries; i > pos; i--)
                    begin
                        deadline_row[i] = deadline_row[i-1];
                        job_row[i]      = job_row[i-1];
                    end
                    deadline_row[pos] = due;
                    job_row[pos]      = job;
                    entries++;
                    owe(sdtq_pkg::STS_SCHEDULED, job, 1'b1);
                end
            end
            sdtq_pkg::CMD_CANCEL:
            begin
                pos = 0;
                while (pos < entries && job_row[pos] != job)
                    pos++;
                if (pos >= entries)
                begin
                    owe(sdtq_pkg::STS_NOT_FOUND, job, 1'b1);
                end
                else
                begin
                    for (i = pos; i + 1 < entries; i++)
                    begin
                        deadline_row[i] = deadline_row[i+1];
                        job_row[i]      = job_row[i+1];
                    end
                    entries--;
                    owe(sdtq_pkg::STS_CANCELLED, job, 1'b1);
                end
            end
            sdtq_pkg::CMD_TICK:
            begin
                n = 0;
                while (n < entries && n < sdtq_pkg::MAX_RESULTS && deadline_row[n] < tnow)
                begin
                    gone[n] = job_row[n];
                    n++;
                end
                if (n == 0)
                begin
                    owe(sdtq_pkg::STS_NONE_DUE, '0, 1'b1);
                end
                else
                begin
                    for (i = 0; i + n < entries; i++)
                    begin
                        deadline_row[i] = deadline_row[i+n];
                        job_row[i]      = job_row[i+n];
                    end
                    entries -= n;
                    for (i = 0; i < n; i++)
                        owe(sdtq_pkg::STS_EXPIRED, gone[i], i + 1 == n);
                end
            end
            default:
            begin
                // The unused command code is taken but leaves no trace.
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        timer_result_t got;
        if (!rst_n)
        begin
            entries = 0;
            answers_owed.delete();
            fail_count = 0;
            owed = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_command(req.cmd, req.job_id, req.delay, req.now);
            if (rsp.valid && rsp.ready)
            begin
                got.status  = rsp.status;
                got.job     = rsp.out_job;
                got.last    = rsp.last;
                got.pending = rsp.pending;
                if (answers_owed.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: result with none owed: status %0d job %0d ",
                                  "last %0d pending %0d"},
                                 $realtime, got.status, got.job, got.last, got.pending);
                end
                else
                begin
                    want = answers_owed.pop_front();
                    if (got.status !== want.status || got.job !== want.job ||
                        got.last !== want.last || got.pending !== want.pending)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch: expected status %0d job %0d last %0d ",
                                      "pending %0d, got status %0d job %0d last %0d pending %0d"},
                                     $realtime, want.status, want.job, want.last, want.pending,
                                     got.status, got.job, got.last, got.pending);
                    end
                end
            end
            owed = answers_owed.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the timer queue testbench: clock, reset, command stimulus and response stalls.
// Depends on sdtq_pkg, sdtq_if.sv, the sorted_deadline_timer_queue RTL and timer_queue_checker.
module tb_top;

    localparam logic [sdtq_pkg::CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int                         RANDOM_CMDS = 100;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   fail_count;
    int   owed;

    logic [sdtq_pkg::JOB_IN_W-1:0]  sched_jobs [$];
    logic [sdtq_pkg::TIME_IN_W-1:0] uptime;

    sdtq_req_if req ();
    sdtq_rsp_if rsp ();

    sorted_deadline_timer_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    timer_queue_checker tq_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .owed       (owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // The response side stalls at random except in the quiet stretch.
    always @(negedge clk)
        rsp.ready <= quiet || ($urandom_range(0, 99) >= 21);

    // Presents one item and returns at the falling edge after it is taken.
    // Valid is left high so the next call can replace the item without a gap.
    task automatic issue(input logic [sdtq_pkg::CMD_W-1:0] cmd,
                         input logic [sdtq_pkg::JOB_IN_W-1:0] job,
                         input logic [sdtq_pkg::TIME_IN_W-1:0] dly,
                         input logic [sdtq_pkg::TIME_IN_W-1:0] tnow);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < 21)
            begin
                req.valid <= 1'b0;
                @(negedge clk);
            end
        end
        req.valid  <= 1'b1;
        req.cmd    <= cmd;
        req.job_id <= job;
        req.delay  <= dly;
        req.now    <= tnow;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    initial
    begin
        int                             done_items;
        int                             pick;
        int                             idx;
        logic [sdtq_pkg::JOB_IN_W-1:0]  job;
        logic [sdtq_pkg::TIME_IN_W-1:0] dly;
        logic [sdtq_pkg::TIME_IN_W-1:0] tnow;

        rst_n      = 1'b0;
        quiet      = 1'b0;
        req.valid  = 1'b0;
        req.cmd    = sdtq_pkg::CMD_SCHEDULE;
        req.job_id = '0;
        req.delay  = '0;
        req.now    = '0;
        rsp.ready  = 1'b0;
        uptime     = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty table, the unused code, saturation, ties and a full table.
        issue(sdtq_pkg::CMD_TICK, 8'hA5, '1, '0);
        issue(sdtq_pkg::CMD_CANCEL, 8'h3C, '0, '0);
        issue(CMD_UNUSED, 8'hFF, '1, '1);
        issue(sdtq_pkg::CMD_SCHEDULE, 8'h00, '0, '0);
        issue(sdtq_pkg::CMD_SCHEDULE, 8'hFF, '1, '1);
        issue(sdtq_pkg::CMD_SCHEDULE, 8'h80, '0, '1);
        issue(sdtq_pkg::CMD_SCHEDULE, 8'h81, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(sdtq_pkg::CMD_TICK, 8'h00, '0, '0);
        issue(sdtq_pkg::CMD_TICK, 8'h00, '0, 32'd1);
        issue(sdtq_pkg::CMD_CANCEL, 8'h80, '0, '0);
        // Thirteen entries with repeated ids and tied deadlines leave one free slot in the table.
        for (int i = 0; i < 13; i++)
            issue(sdtq_pkg::CMD_SCHEDULE, 8'd16 + 8'(i % 5),
                  32'd100 + 32'(i / 4) * 32'd10, 32'd5);
        issue(sdtq_pkg::CMD_SCHEDULE, 8'h55, 32'd1, 32'd0);
        issue(sdtq_pkg::CMD_SCHEDULE, 8'hAA, 32'd1, 32'd0);
        issue(sdtq_pkg::CMD_CANCEL, 8'd18, '0, '0);
        issue(sdtq_pkg::CMD_TICK, 8'h00, '0, '1);
        issue(sdtq_pkg::CMD_CANCEL, 8'hFF, '0, '0);

        // Random part: time mostly moves forward, cancels mostly name a scheduled job.
        done_items = 0;
        while (done_items < RANDOM_CMDS)
        begin
            quiet = (done_items >= 30 && done_items < 60);
            uptime += $urandom_range(0, 10);
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                issue(CMD_UNUSED, sdtq_pkg::JOB_IN_W'($urandom_range(0, 255)),
                      $urandom, $urandom);
            end
            else
            begin
                if (pick < 50)
                begin
                    job  = sdtq_pkg::JOB_IN_W'(($urandom_range(0, 3) == 0)
                                               ? $urandom_range(0, 7)
                                               : $urandom_range(0, 255));
                    dly  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
                    tnow = ($urandom_range(0, 14) == 0) ? $urandom : uptime;
                    sched_jobs.push_back(job);
                    if (sched_jobs.size() > 40)
                        void'(sched_jobs.pop_front());
                    issue(sdtq_pkg::CMD_SCHEDULE, job, dly, tnow);
                end
                else if (pick < 70)
                begin
                    if (sched_jobs.size() != 0 && $urandom_range(0, 3) != 0)
                    begin
                        idx = int'($urandom_range(0, sched_jobs.size() - 1));
                        job = sched_jobs[idx];
                        sched_jobs.delete(idx);
                    end
                    else
                    begin
                        job = sdtq_pkg::JOB_IN_W'($urandom_range(0, 255));
                    end
                    issue(sdtq_pkg::CMD_CANCEL, job, $urandom, $urandom);
                end
                else
                begin
                    uptime += $urandom_range(0, 120);
                    tnow = ($urandom_range(0, 11) == 0) ? $urandom : uptime;
                    issue(sdtq_pkg::CMD_TICK, sdtq_pkg::JOB_IN_W'($urandom_range(0, 255)),
                          $urandom, tnow);
                end
                done_items++;
            end
        end
        quiet = 1'b0;
        req.valid <= 1'b0;

        while (owed != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0 && owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
